@@ src/sbf_pkg.sv @@
// sbf_pkg: widths, thresholds, cause codes and helper functions shared by the
// strand/read bias filter modules. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sbf_pkg;

    // per-sample count width and running-sum width
    localparam int unsigned COUNT_WIDTH = 16;
    localparam int unsigned SUM_WIDTH   = 32;

    // stream payload widths
    localparam int unsigned NUM_COUNTS  = 5;
    localparam int unsigned IN_DATA_W   = ((NUM_COUNTS * COUNT_WIDTH + 7) / 8) * 8;
    localparam int unsigned DEPTH_OUT_W = 32;
    localparam int unsigned OUT_FIELD_W = 1 + 2 + DEPTH_OUT_W + 1;
    localparam int unsigned OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int unsigned OUT_PAD_W   = OUT_DATA_W - OUT_FIELD_W;

    // internal arithmetic widths
    localparam int unsigned INC_W  = COUNT_WIDTH + 1;
    localparam int unsigned ADD_W  = ((SUM_WIDTH > INC_W) ? SUM_WIDTH : INC_W) + 1;
    localparam int unsigned DIFF_W = SUM_WIDTH + 1;
    localparam int unsigned PROD_W = SUM_WIDTH + 17;

    // queue between accumulator and decision pipeline
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // quality exemption minimum
    localparam int unsigned EXEMPT_MIN = 5;

    // deviation scale: |2n - d| * DEV_SCALE > d * T  <=>  dev > T / 100000
    localparam int unsigned DEV_SCALE = 50000;
    localparam int unsigned TH_50     = 49999;
    localparam int unsigned TH_45     = 45000;
    localparam int unsigned TH_40     = 40000;
    localparam int unsigned TH_37     = 37000;
    localparam int unsigned TH_35     = 35000;
    localparam int unsigned TH_34     = 34000;
    localparam int unsigned TH_INDEL  = 7000;

    // depth limits for the strand test
    localparam int unsigned SB_D1 = 30;
    localparam int unsigned SB_D2 = 80;
    localparam int unsigned SB_D3 = 200;
    localparam int unsigned SB_D4 = 500;
    // depth limits for the read test
    localparam int unsigned RB_D0 = 10;
    localparam int unsigned RB_D1 = 40;
    localparam int unsigned RB_D2 = 100;
    localparam int unsigned RB_D3 = 500;

    // cause codes
    localparam logic [1:0] CAUSE_KEEP   = 2'd0;
    localparam logic [1:0] CAUSE_STRAND = 2'd1;
    localparam logic [1:0] CAUSE_READ   = 2'd2;

    // finished sums of one variant
    typedef struct packed {
        logic [SUM_WIDTH-1:0] depth;
        logic [SUM_WIDTH-1:0] reversed;
        logic [SUM_WIDTH-1:0] first_read;
        logic                 exempt;
        logic                 indel;
    } summary_t;

    function automatic logic [SUM_WIDTH-1:0] sat_add(
        input logic [SUM_WIDTH-1:0] acc,
        input logic [INC_W-1:0]     inc
    );
        logic [ADD_W-1:0] sum;
        sum = ADD_W'(acc) + ADD_W'(inc);
        if (sum > ADD_W'({SUM_WIDTH{1'b1}}))
            return {SUM_WIDTH{1'b1}};
        else
            return sum[SUM_WIDTH-1:0];
    endfunction

    function automatic logic [DIFF_W-1:0] abs_dev(
        input logic [SUM_WIDTH-1:0] n,
        input logic [SUM_WIDTH-1:0] d
    );
        logic [DIFF_W-1:0] twice;
        logic [DIFF_W-1:0] dext;
        twice = {n, 1'b0};
        dext  = DIFF_W'(d);
        if (twice >= dext)
            return twice - dext;
        else
            return dext - twice;
    endfunction

    function automatic logic [DEPTH_OUT_W-1:0] depth_clip(input logic [SUM_WIDTH-1:0] d);
        logic [SUM_WIDTH+DEPTH_OUT_W-1:0] w;
        w = (SUM_WIDTH + DEPTH_OUT_W)'(d);
        if (w > (SUM_WIDTH + DEPTH_OUT_W)'({DEPTH_OUT_W{1'b1}}))
            return {DEPTH_OUT_W{1'b1}};
        else
            return w[DEPTH_OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ src/sbf_front.sv @@
// sbf_front: accepts sample records, keeps saturating running sums and the
// exemption/indel flags, and hands one summary per variant to the queue. Uses sbf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbf_front (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              rec_valid,
    output logic                             rec_ready,
    input  wire  [sbf_pkg::COUNT_WIDTH-1:0]  high_quality_support,
    input  wire  [sbf_pkg::COUNT_WIDTH-1:0]  low_quality_support,
    input  wire  [sbf_pkg::COUNT_WIDTH-1:0]  proper_pair_count,
    input  wire  [sbf_pkg::COUNT_WIDTH-1:0]  reversed_count,
    input  wire  [sbf_pkg::COUNT_WIDTH-1:0]  first_read_count,
    input  wire                              indel_flag,
    input  wire                              last_sample,
    output logic                             push,
    output sbf_pkg::summary_t                push_data,
    input  wire                              push_ready
);
    import sbf_pkg::*;

    logic [SUM_WIDTH-1:0] depth_sum_reg, depth_sum_next;
    logic [SUM_WIDTH-1:0] rev_sum_reg, rev_sum_next;
    logic [SUM_WIDTH-1:0] first_sum_reg, first_sum_next;
    logic                 exempt_reg, exempt_next;
    logic                 indel_reg, indel_next;
    logic                 first_rec_reg, first_rec_next;

    logic                 accept;
    logic [SUM_WIDTH-1:0] depth_upd, rev_upd, first_upd;
    logic                 exempt_upd, indel_upd;

    // records are only taken while the queue can hold a summary
    assign rec_ready = push_ready;
    assign accept    = rec_valid && rec_ready;

    always_comb
    begin
        depth_upd  = sat_add(depth_sum_reg,
                             INC_W'(high_quality_support) + INC_W'(low_quality_support));
        rev_upd    = sat_add(rev_sum_reg, INC_W'(reversed_count));
        first_upd  = sat_add(first_sum_reg, INC_W'(first_read_count));
        exempt_upd = exempt_reg
                     || ((high_quality_support >= COUNT_WIDTH'(EXEMPT_MIN))
                         && (proper_pair_count >= COUNT_WIDTH'(EXEMPT_MIN)));
        indel_upd  = first_rec_reg ? indel_flag : indel_reg;

        push_data.depth      = depth_upd;
        push_data.reversed   = rev_upd;
        push_data.first_read = first_upd;
        push_data.exempt     = exempt_upd;
        push_data.indel      = indel_upd;
        push                 = accept && last_sample;

        depth_sum_next = depth_sum_reg;
        rev_sum_next   = rev_sum_reg;
        first_sum_next = first_sum_reg;
        exempt_next    = exempt_reg;
        indel_next     = indel_reg;
        first_rec_next = first_rec_reg;
        if (accept)
        begin
            if (last_sample)
            begin
                // variant done, start fresh
                depth_sum_next = '0;
                rev_sum_next   = '0;
                first_sum_next = '0;
                exempt_next    = 1'b0;
                indel_next     = 1'b0;
                first_rec_next = 1'b1;
            end
            else
            begin
                depth_sum_next = depth_upd;
                rev_sum_next   = rev_upd;
                first_sum_next = first_upd;
                exempt_next    = exempt_upd;
                indel_next     = indel_upd;
                first_rec_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_sum_reg <= '0;
            rev_sum_reg   <= '0;
            first_sum_reg <= '0;
            exempt_reg    <= 1'b0;
            indel_reg     <= 1'b0;
            first_rec_reg <= 1'b1;
        end
        else
        begin
            depth_sum_reg <= depth_sum_next;
            rev_sum_reg   <= rev_sum_next;
            first_sum_reg <= first_sum_next;
            exempt_reg    <= exempt_next;
            indel_reg     <= indel_next;
            first_rec_reg <= first_rec_next;
        end
    end

endmodule

`default_nettype wire

@@ src/sbf_queue.sv @@
// sbf_queue: short first-in first-out queue of variant summaries between the
// accumulator and the decision pipeline. Uses sbf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbf_queue (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    input  wire sbf_pkg::summary_t push_data,
    output logic                push_ready,
    output logic                pop_valid,
    output sbf_pkg::summary_t   pop_data,
    input  wire                 pop
);
    import sbf_pkg::*;

    summary_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ src/sbf_back.sv @@
// sbf_back: three-stage decision pipeline (deviation, products, compare and
// result register) with per-stage stall. Uses sbf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbf_back (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    input  wire sbf_pkg::summary_t              in_data,
    output logic                                in_pop,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic                                remove,
    output logic [1:0]                          cause,
    output logic [sbf_pkg::DEPTH_OUT_W-1:0]     summed_depth,
    output logic                                quality_exempt
);
    import sbf_pkg::*;

    // stage a: absolute deviations
    logic                 a_valid_reg, a_valid_next;
    logic [SUM_WIDTH-1:0] a_depth_reg;
    logic [DIFF_W-1:0]    a_diff_r_reg, a_diff_f_reg;
    logic                 a_exempt_reg, a_indel_reg;

    // stage b: products against every threshold
    logic                 b_valid_reg, b_valid_next;
    logic [SUM_WIDTH-1:0] b_depth_reg;
    logic                 b_exempt_reg, b_indel_reg;
    logic [PROD_W-1:0]    b_dev_r_reg, b_dev_f_reg;
    logic [PROD_W-1:0]    b_th50_reg, b_th45_reg, b_th40_reg, b_th37_reg;
    logic [PROD_W-1:0]    b_th35_reg, b_th34_reg, b_thin_reg;

    // stage c: result register
    logic                   c_valid_reg, c_valid_next;
    logic                   c_remove_reg;
    logic [1:0]             c_cause_reg;
    logic [DEPTH_OUT_W-1:0] c_depth_reg;
    logic                   c_exempt_reg;

    logic              a_adv, b_adv, c_adv;
    logic [PROD_W-1:0] add_in;
    logic              sb_hit, rb_hit;
    logic [1:0]        cause_calc;

    assign c_adv  = !c_valid_reg || out_ready;
    assign b_adv  = !b_valid_reg || c_adv;
    assign a_adv  = !a_valid_reg || b_adv;
    assign in_pop = in_valid && a_adv;

    assign a_valid_next = a_adv ? in_valid : a_valid_reg;
    assign b_valid_next = b_adv ? a_valid_reg : b_valid_reg;
    assign c_valid_next = c_adv ? b_valid_reg : c_valid_reg;

    // indels widen every strand threshold by 0.07
    always_comb
    begin
        add_in = b_indel_reg ? b_thin_reg : '0;
        sb_hit = (b_dev_r_reg > b_th50_reg + add_in)
                 || ((b_depth_reg > SUM_WIDTH'(SB_D1)) && (b_dev_r_reg > b_th45_reg + add_in))
                 || ((b_depth_reg > SUM_WIDTH'(SB_D2)) && (b_dev_r_reg > b_th40_reg + add_in))
                 || ((b_depth_reg > SUM_WIDTH'(SB_D3)) && (b_dev_r_reg > b_th37_reg + add_in))
                 || ((b_depth_reg > SUM_WIDTH'(SB_D4)) && (b_dev_r_reg > b_th34_reg + add_in));
        rb_hit = ((b_depth_reg > SUM_WIDTH'(RB_D0)) && (b_dev_f_reg > b_th50_reg))
                 || ((b_depth_reg > SUM_WIDTH'(RB_D1)) && (b_dev_f_reg > b_th45_reg))
                 || ((b_depth_reg > SUM_WIDTH'(RB_D2)) && (b_dev_f_reg > b_th40_reg))
                 || ((b_depth_reg > SUM_WIDTH'(RB_D3)) && (b_dev_f_reg > b_th35_reg));
        priority if (b_exempt_reg || (b_depth_reg == '0))
            cause_calc = CAUSE_KEEP;
        else if (sb_hit)
            cause_calc = CAUSE_STRAND;
        else if (!b_indel_reg && rb_hit)
            cause_calc = CAUSE_READ;
        else
            cause_calc = CAUSE_KEEP;
    end

    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            a_depth_reg  <= in_data.depth;
            a_diff_r_reg <= abs_dev(in_data.reversed, in_data.depth);
            a_diff_f_reg <= abs_dev(in_data.first_read, in_data.depth);
            a_exempt_reg <= in_data.exempt;
            a_indel_reg  <= in_data.indel;
        end
        if (b_adv)
        begin
            b_depth_reg  <= a_depth_reg;
            b_exempt_reg <= a_exempt_reg;
            b_indel_reg  <= a_indel_reg;
            b_dev_r_reg  <= PROD_W'(a_diff_r_reg) * PROD_W'(DEV_SCALE);
            b_dev_f_reg  <= PROD_W'(a_diff_f_reg) * PROD_W'(DEV_SCALE);
            b_th50_reg   <= PROD_W'(a_depth_reg) * PROD_W'(TH_50);
            b_th45_reg   <= PROD_W'(a_depth_reg) * PROD_W'(TH_45);
            b_th40_reg   <= PROD_W'(a_depth_reg) * PROD_W'(TH_40);
            b_th37_reg   <= PROD_W'(a_depth_reg) * PROD_W'(TH_37);
            b_th35_reg   <= PROD_W'(a_depth_reg) * PROD_W'(TH_35);
            b_th34_reg   <= PROD_W'(a_depth_reg) * PROD_W'(TH_34);
            b_thin_reg   <= PROD_W'(a_depth_reg) * PROD_W'(TH_INDEL);
        end
        if (c_adv)
        begin
            c_remove_reg <= (cause_calc != CAUSE_KEEP);
            c_cause_reg  <= cause_calc;
            c_depth_reg  <= depth_clip(b_depth_reg);
            c_exempt_reg <= b_exempt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    assign out_valid      = c_valid_reg;
    assign remove         = c_remove_reg;
    assign cause          = c_cause_reg;
    assign summed_depth   = c_depth_reg;
    assign quality_exempt = c_exempt_reg;

endmodule

`default_nettype wire

@@ src/strand_read_bias_filter.sv @@
// strand_read_bias_filter: top level; accumulator front, summary queue and
// decision pipeline back. Uses sbf_pkg, sbf_front, sbf_queue, sbf_back.
//
//  channel   dir   carries                                   ends with
//  s_axis    in    one sample record per transaction         tlast on last sample
//  m_axis    out   keep/remove decision per variant          -
//
// one record is taken per cycle while the summary queue has room.
// a decision for a variant passes from its last record through one queue write,
// then the deviation, product and compare/result stages.
// each back stage stalls on its own; the queue lets the front keep going.
// reset clears the running sums, the queue and all pipeline valid bits.
`timescale 1ns / 1ps
`default_nettype none

module strand_read_bias_filter (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // high_quality_support, low_quality_support, proper_pair_count,
    // reversed_count, first_read_count
    input  wire  [sbf_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // indel_flag
    input  wire                               s_axis_tuser,
    input  wire                               s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // remove, cause, summed_depth, quality_exempt, zero pad
    output logic [sbf_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import sbf_pkg::*;

    logic                   push, push_ready;
    summary_t               push_data;
    logic                   pop_valid, pop;
    summary_t               pop_data;
    logic                   remove, quality_exempt;
    logic [1:0]             cause;
    logic [DEPTH_OUT_W-1:0] summed_depth;

    sbf_front u_front (
        .clk                  (clk),
        .rst_n                (rst_n),
        .rec_valid            (s_axis_tvalid),
        .rec_ready            (s_axis_tready),
        .high_quality_support (s_axis_tdata[0*COUNT_WIDTH +: COUNT_WIDTH]),
        .low_quality_support  (s_axis_tdata[1*COUNT_WIDTH +: COUNT_WIDTH]),
        .proper_pair_count    (s_axis_tdata[2*COUNT_WIDTH +: COUNT_WIDTH]),
        .reversed_count       (s_axis_tdata[3*COUNT_WIDTH +: COUNT_WIDTH]),
        .first_read_count     (s_axis_tdata[4*COUNT_WIDTH +: COUNT_WIDTH]),
        .indel_flag           (s_axis_tuser),
        .last_sample          (s_axis_tlast),
        .push                 (push),
        .push_data            (push_data),
        .push_ready           (push_ready)
    );

    sbf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop        (pop)
    );

    sbf_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (pop_valid),
        .in_data        (pop_data),
        .in_pop         (pop),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .remove         (remove),
        .cause          (cause),
        .summed_depth   (summed_depth),
        .quality_exempt (quality_exempt)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, quality_exempt, summed_depth, cause, remove};

endmodule

`default_nettype wire

@@ bench/strand_read_bias_filter_tb.sv @@
// strand_read_bias_filter_tb: self-checking bench for the strand/read bias filter.
// Streams sample records with random idling on both sides and checks every verdict
// against its own running model of the sums and bias tests. Depends on sbf_pkg and strand_read_bias_filter.
`timescale 1ns / 1ps

module strand_read_bias_filter_tb;

    // deviation thresholds scaled by 1e5, compared as |2n - d| * 50000 > d * t
    localparam int unsigned LIM_HALF   = 49999;
    localparam int unsigned LIM_45     = 45000;
    localparam int unsigned LIM_40     = 40000;
    localparam int unsigned LIM_37     = 37000;
    localparam int unsigned LIM_35     = 35000;
    localparam int unsigned LIM_34     = 34000;
    localparam int unsigned INDEL_ALLOW = 7000;
    localparam int unsigned PHASE_ITEMS = 617;
    localparam int unsigned MAX_REPORTS = 50;

    typedef struct packed {
        logic [15:0] hq;
        logic [15:0] lq;
        logic [15:0] pp;
        logic [15:0] rev;
        logic [15:0] first;
        logic        indel;
        logic        last;
    } record_t;

    typedef struct packed {
        logic        remove;
        logic [1:0]  cause;
        logic [31:0] depth;
        logic        exempt;
    } verdict_t;

    typedef struct packed {
        record_t  rec;
        logic     typed;
        verdict_t want;
    } directed_row_t;

    localparam int unsigned NUM_ROWS = 22;
    localparam logic [1:0] KEEP   = sbf_pkg::CAUSE_KEEP;
    localparam logic [1:0] STRAND = sbf_pkg::CAUSE_STRAND;
    localparam logic [1:0] READ   = sbf_pkg::CAUSE_READ;
    localparam verdict_t NONE = '{1'b0, 2'd0, 32'd0, 1'b0};

    // fields: hq, lq, pp, rev, first, indel, last | typed | remove, cause, depth, exempt
    localparam directed_row_t DIRECTED [NUM_ROWS] = '{
        // zero record right after reset
        '{'{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1}, 1'b1, '{1'b0, KEEP, 32'd0, 1'b0}},
        // all counts but proper_pair_count at their maximum, balanced strands
        '{'{16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1}, 1'b1,
          '{1'b0, KEEP, 32'd131070, 1'b0}},
        // quality exemption at its minimum
        '{'{16'd5, 16'd0, 16'd5, 16'd0, 16'd0, 1'b0, 1'b1}, 1'b1, '{1'b0, KEEP, 32'd5, 1'b1}},
        // one short of exemption on either count
        '{'{16'd4, 16'd0, 16'd5, 16'd0, 16'd0, 1'b0, 1'b1}, 1'b1,
          '{1'b1, STRAND, 32'd4, 1'b0}},
        '{'{16'd5, 16'd0, 16'd4, 16'd0, 16'd0, 1'b0, 1'b1}, 1'b1,
          '{1'b1, STRAND, 32'd5, 1'b0}},
        // indel: full one-sided strand is within the allowance, read test skipped
        '{'{16'd10, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1}, 1'b1, '{1'b0, KEEP, 32'd10, 1'b0}},
        // read bias on a balanced strand
        '{'{16'd20, 16'd0, 16'd0, 16'd10, 16'd0, 1'b0, 1'b1}, 1'b1,
          '{1'b1, READ, 32'd20, 1'b0}},
        // reversed count far above depth
        '{'{16'd1, 16'd0, 16'd0, 16'hFFFF, 16'd0, 1'b0, 1'b1}, 1'b1,
          '{1'b1, STRAND, 32'd1, 1'b0}},
        // zero depth with nonzero strand counts
        '{'{16'd0, 16'd0, 16'd0, 16'd5, 16'd5, 1'b0, 1'b1}, 1'b1, '{1'b0, KEEP, 32'd0, 1'b0}},
        // low quality only
        '{'{16'd0, 16'd100, 16'd0, 16'd50, 16'd50, 1'b0, 1'b1}, 1'b1,
          '{1'b0, KEEP, 32'd100, 1'b0}},
        // indel flag comes from the first record only
        '{'{16'd3, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0}, 1'b0, NONE},
        '{'{16'd3, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1}, 1'b0, NONE},
        '{'{16'd15, 16'd0, 16'd0, 16'd7, 16'd0, 1'b0, 1'b0}, 1'b0, NONE},
        '{'{16'd15, 16'd0, 16'd0, 16'd8, 16'd15, 1'b1, 1'b1}, 1'b0, NONE},
        // exemption in a middle record, then a fresh variant without it
        '{'{16'd2, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0}, 1'b0, NONE},
        '{'{16'd6, 16'd0, 16'd9, 16'd0, 16'd0, 1'b0, 1'b0}, 1'b0, NONE},
        '{'{16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1}, 1'b0, NONE},
        '{'{16'd2, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1}, 1'b0, NONE},
        // depth-gated thresholds near their edges
        '{'{16'd31, 16'd0, 16'd0, 16'd2, 16'd1, 1'b0, 1'b1}, 1'b0, NONE},
        '{'{16'd41, 16'd0, 16'd0, 16'd20, 16'd1, 1'b0, 1'b1}, 1'b0, NONE},
        '{'{16'd600, 16'd0, 16'd0, 16'd100, 16'd90, 1'b0, 1'b1}, 1'b0, NONE},
        '{'{16'd300, 16'd300, 16'd4, 16'd100, 16'd89, 1'b0, 1'b1}, 1'b0, NONE}
    };

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [sbf_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                           s_axis_tuser = 1'b0;
    logic                           s_axis_tlast = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [sbf_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    // running sums of the variant being collected
    logic [31:0] acc_depth = '0;
    logic [31:0] acc_reversed = '0;
    logic [31:0] acc_first = '0;
    logic        acc_exempt = 1'b0;
    logic        acc_indel = 1'b0;
    logic        acc_fresh = 1'b1;

    verdict_t    pending_verdicts[$];
    int unsigned error_count = 0;
    int unsigned phase_items = 0;
    int unsigned src_idle_pct = 0;
    int unsigned sink_idle_pct = 0;

    strand_read_bias_filter uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [31:0] sum_clamped(input logic [31:0] acc, input logic [16:0] inc);
        logic [32:0] s;
        s = {1'b0, acc} + {16'd0, inc};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic bit dev_exceeds(input logic [31:0] n, input logic [31:0] d,
                                       input int unsigned lim);
        logic [63:0] twice_n;
        logic [63:0] dd;
        logic [63:0] diff;
        twice_n = {31'd0, n, 1'b0};
        dd = {32'd0, d};
        diff = (twice_n >= dd) ? twice_n - dd : dd - twice_n;
        return (diff * 64'd50000) > (dd * 64'(lim));
    endfunction

    function automatic bit strand_fault(input logic [31:0] d, input logic [31:0] r,
                                        input logic indel);
        int unsigned extra;
        extra = indel ? INDEL_ALLOW : 0;
        return dev_exceeds(r, d, LIM_HALF + extra) ||
               (d > 30 && dev_exceeds(r, d, LIM_45 + extra)) ||
               (d > 80 && dev_exceeds(r, d, LIM_40 + extra)) ||
               (d > 200 && dev_exceeds(r, d, LIM_37 + extra)) ||
               (d > 500 && dev_exceeds(r, d, LIM_34 + extra));
    endfunction

    function automatic bit read_fault(input logic [31:0] d, input logic [31:0] f);
        return (d > 10 && dev_exceeds(f, d, LIM_HALF)) ||
               (d > 40 && dev_exceeds(f, d, LIM_45)) ||
               (d > 100 && dev_exceeds(f, d, LIM_40)) ||
               (d > 500 && dev_exceeds(f, d, LIM_35));
    endfunction

    // folds one record into the running sums; returns 1 with the verdict on a last record
    function automatic bit absorb_record(input record_t r, output verdict_t v);
        logic [1:0] cause;
        cause = KEEP;
        v = NONE;
        if (acc_fresh)
            acc_indel = r.indel;
        acc_fresh = 1'b0;
        acc_depth = sum_clamped(acc_depth, {1'b0, r.hq} + {1'b0, r.lq});
        acc_reversed = sum_clamped(acc_reversed, {1'b0, r.rev});
        acc_first = sum_clamped(acc_first, {1'b0, r.first});
        if (r.hq >= 5 && r.pp >= 5)
            acc_exempt = 1'b1;
        if (!r.last)
            return 1'b0;
        if (!acc_exempt && acc_depth != 0)
        begin
            if (strand_fault(acc_depth, acc_reversed, acc_indel))
                cause = STRAND;
            else if (!acc_indel && read_fault(acc_depth, acc_first))
                cause = READ;
        end
        v = '{cause != KEEP, cause, acc_depth, acc_exempt};
        acc_depth = '0;
        acc_reversed = '0;
        acc_first = '0;
        acc_exempt = 1'b0;
        acc_indel = 1'b0;
        acc_fresh = 1'b1;
        return 1'b1;
    endfunction

    // drives one record until it is taken; the verdict used is the typed one when given
    task automatic send_record(input record_t r, input logic typed, input verdict_t want);
        verdict_t v;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {r.first, r.rev, r.pp, r.lq, r.hq};
        s_axis_tuser <= r.indel;
        s_axis_tlast <= r.last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        phase_items++;
        if (absorb_record(r, v))
            pending_verdicts = {pending_verdicts, (typed ? want : v)};
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_verdicts.size() != 0);
    endtask

    function automatic logic [15:0] pick_strand_count(input logic [15:0] hq,
                                                      input logic [15:0] lq);
        int unsigned depth;
        int unsigned mode;
        depth = hq + lq;
        if (depth > 65535)
            depth = 65535;
        mode = $urandom_range(0, 99);
        if (mode < 10)
            return 16'd0;
        else if (mode < 20)
            return 16'(depth);
        else if (mode < 25)
            return 16'($urandom_range(0, 65535));
        else
            return 16'($urandom_range(0, depth));
    endfunction

    task automatic send_random_variant();
        int unsigned len;
        int unsigned cmax;
        int unsigned sel;
        record_t r;
        sel = $urandom_range(0, 99);
        len = (sel < 60) ? $urandom_range(1, 3) :
              (sel < 90) ? $urandom_range(4, 10) : $urandom_range(11, 40);
        sel = $urandom_range(0, 99);
        cmax = (sel < 35) ? 15 : (sel < 75) ? 300 : 65535;
        for (int unsigned i = 0; i < len; i++)
        begin
            r.hq = 16'($urandom_range(0, cmax));
            r.lq = 16'($urandom_range(0, cmax));
            // exemption kept rare so the bias tests get exercised
            r.pp = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 4))
                                                 : 16'($urandom_range(0, 65535));
            r.rev = pick_strand_count(r.hq, r.lq);
            r.first = pick_strand_count(r.hq, r.lq);
            r.indel = ($urandom_range(0, 99) < 30);
            r.last = (i == len - 1);
            send_record(r, 1'b0, NONE);
        end
    endtask

    // result side: random stalls, checks each transaction against the oldest verdict
    always @(posedge clk)
    begin
        verdict_t exp_v;
        verdict_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.remove = m_axis_tdata[0];
            got.cause = m_axis_tdata[2:1];
            got.depth = m_axis_tdata[34:3];
            got.exempt = m_axis_tdata[35];
            if (pending_verdicts.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $error("unexpected result transaction: %h", m_axis_tdata);
            end
            else
            begin
                exp_v = pending_verdicts.pop_front();
                if (got !== exp_v)
                    error_count++;
                // keep the log readable when the block is badly off
                if (error_count <= MAX_REPORTS)
                begin
                    if (got.remove !== exp_v.remove)
                        $error("remove: expected %0d, got %0d", exp_v.remove, got.remove);
                    if (got.cause !== exp_v.cause)
                        $error("cause: expected %0d, got %0d", exp_v.cause, got.cause);
                    if (got.depth !== exp_v.depth)
                        $error("summed_depth: expected %0d, got %0d", exp_v.depth, got.depth);
                    if (got.exempt !== exp_v.exempt)
                        $error("quality_exempt: expected %0d, got %0d",
                               exp_v.exempt, got.exempt);
                end
            end
        end
        m_axis_tready <= rst_n && ($urandom_range(0, 99) >= sink_idle_pct);
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 24;
        sink_idle_pct = 52;
        for (int unsigned i = 0; i < NUM_ROWS; i++)
            send_record(DIRECTED[i].rec, DIRECTED[i].typed, DIRECTED[i].want);
        hold_until_drained();

        for (int unsigned phase = 0; phase < 3; phase++)
        begin
            src_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 52 : 0;
            sink_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 24 : 0;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                send_random_variant();
                if ($urandom_range(0, 99) < 3)
                    hold_until_drained();
            end
            hold_until_drained();
        end

        // let any stray result surface
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #(10_000_000);
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
src/sbf_pkg.sv
src/sbf_front.sv
src/sbf_queue.sv
src/sbf_back.sv
src/strand_read_bias_filter.sv
bench/strand_read_bias_filter_tb.sv
